FILE: hdl/chip8_instruction_execute_core_macros.svh
// Assertion macros shared by the checker of the instruction execute core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CHIP8_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHIP8IE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("instruction execute core: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHIP8IE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("instruction execute core: assertion failed");

`endif

FILE: hdl/chip8ie_pkg.sv
// Package for the CHIP-8 instruction execute core: payload types, control
// structs, opcode and status codes, and sizing constants. No dependencies.
package chip8ie_pkg;

    // Sizing of the return-address stack.
    localparam int STACK_DEPTH = 16;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Data register file.
    localparam int NUM_REGS  = 16;
    localparam int REG_W     = 8;
    localparam int RIDX_W    = $clog2(NUM_REGS);
    localparam int PC_W      = 12;
    localparam logic [RIDX_W-1:0] VF_INDEX = 4'hF;

    // Whole-word opcodes.
    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    // Top-nibble opcode groups.
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SEI  = 4'h3;
    localparam logic [3:0] GRP_SNEI = 4'h4;
    localparam logic [3:0] GRP_SER  = 4'h5;
    localparam logic [3:0] GRP_LDI  = 4'h6;
    localparam logic [3:0] GRP_ADDI = 4'h7;
    localparam logic [3:0] GRP_ALU  = 4'h8;

    // Register-register ALU operations (low nibble of the 8xyN group).
    localparam logic [3:0] ALU_LD  = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] SER_TAIL = 4'h0;

    // Stack status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

    // Request payload.
    typedef struct packed {
        logic [15:0]     instruction;
        logic [PC_W-1:0] current_pc;
    } instr_t;

    // Result payload.
    typedef struct packed {
        logic [PC_W-1:0]  next_pc;
        logic             clear_screen;
        logic [REG_W-1:0] x_value;
        logic [REG_W-1:0] carry_flag;
        logic [1:0]       stack_status;
    } result_t;

    // Write to the V0..VE register memory.
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [REG_W-1:0]  data;
    } rf_wr_t;

    // Write to the VF flag register.
    typedef struct packed {
        logic             en;
        logic [REG_W-1:0] data;
    } vf_wr_t;

    // Return-stack operation.
    typedef struct packed {
        logic            push;
        logic            pop;
        logic [PC_W-1:0] pc;
    } stk_op_t;

endpackage

FILE: hdl/chip8ie_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module chip8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports; a read in the cycle of a write sees old data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

FILE: hdl/chip8ie_stack.sv
// Return-address stack of the instruction execute core.
// Depends on chip8ie_pkg.
module chip8ie_stack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  chip8ie_pkg::stk_op_t          op,
    output logic [chip8ie_pkg::LVL_W-1:0] level,
    output logic [chip8ie_pkg::PC_W-1:0]  top
);
    import chip8ie_pkg::*;

    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic [PC_W-1:0]  stack_reg [STACK_DEPTH];
    logic [LVL_W-1:0] top_pos;

    // Entry below the level is the most recent return address.
    assign top_pos = level_reg - LVL_W'(1);
    assign top     = stack_reg[top_pos[IDX_W-1:0]];
    assign level   = level_reg;

    // Level update; callers only push when not full and pop when not empty.
    always_comb
    begin
        level_next = level_reg;
        if (op.push)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (op.pop)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    // Stack entries hold payload only and need no reset.
    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            stack_reg[level_reg[IDX_W-1:0]] <= op.pc;
        end
    end

endmodule

FILE: hdl/chip8ie_exec.sv
// Combinational execute logic: decodes one opcode and works out the result,
// the register writes and the stack operation. Depends on chip8ie_pkg.
module chip8ie_exec (
    input  chip8ie_pkg::instr_t            item,
    input  logic [chip8ie_pkg::REG_W-1:0]  vx,
    input  logic [chip8ie_pkg::REG_W-1:0]  vy,
    input  logic [chip8ie_pkg::REG_W-1:0]  vf,
    input  logic [chip8ie_pkg::LVL_W-1:0]  level,
    input  logic [chip8ie_pkg::PC_W-1:0]   top,
    output chip8ie_pkg::result_t           result,
    output chip8ie_pkg::rf_wr_t            rf_wr,
    output chip8ie_pkg::vf_wr_t            vf_wr,
    output chip8ie_pkg::stk_op_t           stk_op
);
    import chip8ie_pkg::*;

    logic [15:0]       op;
    logic [3:0]        grp;
    logic [3:0]        tail;
    logic [RIDX_W-1:0] x_idx;
    logic [REG_W-1:0]  kk;
    logic [PC_W-1:0]   nnn;
    logic [PC_W-1:0]   pc;
    logic [PC_W-1:0]   pc_skip;
    logic [REG_W:0]    sum;
    logic              write_x;
    logic [REG_W-1:0]  new_vx;
    logic              set_carry;
    logic              stk_full;
    logic              stk_empty;

    assign op        = item.instruction;
    assign grp       = op[15:12];
    assign tail      = op[3:0];
    assign x_idx     = op[11:8];
    assign kk        = op[7:0];
    assign nnn       = op[11:0];
    assign pc        = item.current_pc;
    assign pc_skip   = pc + PC_W'(2);
    assign sum       = {1'b0, vx} + {1'b0, vy};
    assign stk_full  = (level >= LVL_W'(STACK_DEPTH));
    assign stk_empty = (level == '0);

    // Decode and execute.
    always_comb
    begin
        result.next_pc      = pc;
        result.clear_screen = 1'b0;
        result.stack_status = STAT_OK;
        write_x             = 1'b0;
        new_vx              = vx;
        set_carry           = 1'b0;
        stk_op.push         = 1'b0;
        stk_op.pop          = 1'b0;
        stk_op.pc           = pc;

        if (op == OP_CLS)
        begin
            result.clear_screen = 1'b1;
        end
        else if (op == OP_RET)
        begin
            if (stk_empty)
            begin
                result.stack_status = STAT_UNDERFLOW;
            end
            else
            begin
                stk_op.pop     = 1'b1;
                result.next_pc = top;
            end
        end
        else
        begin
            case (grp)
                GRP_JP:
                begin
                    result.next_pc = nnn;
                end
                GRP_CALL:
                begin
                    if (stk_full)
                    begin
                        result.stack_status = STAT_OVERFLOW;
                    end
                    else
                    begin
                        stk_op.push = 1'b1;
                    end
                    result.next_pc = nnn;
                end
                GRP_SEI:
                begin
                    if (vx == kk)
                    begin
                        result.next_pc = pc_skip;
                    end
                end
                GRP_SNEI:
                begin
                    if (vx != kk)
                    begin
                        result.next_pc = pc_skip;
                    end
                end
                GRP_SER:
                begin
                    if ((tail == SER_TAIL) && (vx == vy))
                    begin
                        result.next_pc = pc_skip;
                    end
                end
                GRP_LDI:
                begin
                    write_x = 1'b1;
                    new_vx  = kk;
                end
                GRP_ADDI:
                begin
                    write_x = 1'b1;
                    new_vx  = vx + kk;
                end
                GRP_ALU:
                begin
                    case (tail)
                        ALU_LD:
                        begin
                            write_x = 1'b1;
                            new_vx  = vy;
                        end
                        ALU_OR:
                        begin
                            write_x = 1'b1;
                            new_vx  = vx | vy;
                        end
                        ALU_AND:
                        begin
                            write_x = 1'b1;
                            new_vx  = vx & vy;
                        end
                        ALU_XOR:
                        begin
                            write_x = 1'b1;
                            new_vx  = vx ^ vy;
                        end
                        ALU_ADD:
                        begin
                            write_x   = 1'b1;
                            set_carry = 1'b1;
                            new_vx    = sum[REG_W-1:0];
                        end
                        default:
                        begin
                            write_x = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    result.next_pc = pc;
                end
            endcase
        end

        // VF gets the carry first; a write of Vx to VF itself then wins.
        rf_wr.en   = write_x && (x_idx != VF_INDEX);
        rf_wr.addr = x_idx;
        rf_wr.data = new_vx;
        vf_wr.en   = set_carry || (write_x && (x_idx == VF_INDEX));
        vf_wr.data = (write_x && (x_idx == VF_INDEX)) ? new_vx
                                                      : {{(REG_W-1){1'b0}}, sum[REG_W]};

        result.x_value    = new_vx;
        result.carry_flag = vf_wr.en ? vf_wr.data : vf;
    end

endmodule

FILE: hdl/chip8_instruction_execute_core.sv
// Top level of the CHIP-8 instruction execute core: request register,
// register memory with forwarding, VF flag, return stack and result register.
// Depends on chip8ie_pkg, chip8ie_ram, chip8ie_stack and chip8ie_exec.
//
//   Channel   Handshake                     Payload
//   request   instr_valid / instr_ready     instr_data  (instruction, current_pc)
//   result    result_valid / result_ready   result_data (next_pc .. stack_status)
//
// One instruction is accepted in every cycle while the result does not stall;
// its result is registered from the request register when the step fires.
// The V0..VE memory is read at the accepting edge, alongside the request
// register, and a write from the instruction ahead is forwarded into that read.
// Reset clears V0..VF (by valid bits and the VF register), the stack level and
// all handshake state. A stalled result holds the instruction behind it in the
// request register, and instr_ready falls until the result is taken.
module chip8_instruction_execute_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 instr_valid,
    output logic                 instr_ready,
    input  chip8ie_pkg::instr_t  instr_data,
    output logic                 result_valid,
    input  logic                 result_ready,
    output chip8ie_pkg::result_t result_data
);
    import chip8ie_pkg::*;

    logic                in_valid_reg;
    instr_t              in_item_reg;
    logic                result_valid_reg;
    result_t             result_reg;
    logic                accept;
    logic                fire;

    logic [NUM_REGS-1:0] rf_valid_reg;
    logic [REG_W-1:0]    vf_reg;
    logic                hit_x_reg;
    logic                hit_y_reg;
    logic                vld_x_reg;
    logic                vld_y_reg;
    logic [REG_W-1:0]    fwd_data_reg;
    logic [RIDX_W-1:0]   rd_x;
    logic [RIDX_W-1:0]   rd_y;
    logic [REG_W-1:0]    ram_x;
    logic [REG_W-1:0]    ram_y;
    logic [RIDX_W-1:0]   ex_x;
    logic [RIDX_W-1:0]   ex_y;
    logic [REG_W-1:0]    vx;
    logic [REG_W-1:0]    vy;

    logic [LVL_W-1:0]    stk_level;
    logic [PC_W-1:0]     stk_top;
    result_t             ex_result;
    rf_wr_t              ex_rf_wr;
    vf_wr_t              ex_vf_wr;
    stk_op_t             ex_stk_op;
    rf_wr_t              rf_wr;
    stk_op_t             stk_op;

    // Handshake: the execute step fires when the result register is free.
    assign fire         = in_valid_reg && (!result_valid_reg || result_ready);
    assign instr_ready  = !in_valid_reg || fire;
    assign accept       = instr_valid && instr_ready;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // Writes and stack operations take effect only when the step fires.
    always_comb
    begin
        rf_wr        = ex_rf_wr;
        rf_wr.en     = ex_rf_wr.en && fire;
        stk_op       = ex_stk_op;
        stk_op.push  = ex_stk_op.push && fire;
        stk_op.pop   = ex_stk_op.pop && fire;
    end

    // Register memory reads at request time.
    assign rd_x = instr_data.instruction[11:8];
    assign rd_y = instr_data.instruction[7:4];

    chip8ie_ram #(
        .WIDTH (REG_W),
        .DEPTH (NUM_REGS)
    ) u_regs (
        .clk       (clk),
        .wr_en     (rf_wr.en),
        .wr_addr   (rf_wr.addr),
        .wr_data   (rf_wr.data),
        .rd_en     (accept),
        .rd_addr_a (rd_x),
        .rd_addr_b (rd_y),
        .rd_data_a (ram_x),
        .rd_data_b (ram_y)
    );

    // Request register, forwarding flags and read-valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg  <= instr_data;
            hit_x_reg    <= rf_wr.en && (rf_wr.addr == rd_x);
            hit_y_reg    <= rf_wr.en && (rf_wr.addr == rd_y);
            vld_x_reg    <= rf_valid_reg[rd_x];
            vld_y_reg    <= rf_valid_reg[rd_y];
            fwd_data_reg <= rf_wr.data;
        end
    end

    // Valid bits make never-written registers read as zero after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
        end
        else if (rf_wr.en)
        begin
            rf_valid_reg[rf_wr.addr] <= 1'b1;
        end
    end

    // VF flag register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= '0;
        end
        else if (fire && ex_vf_wr.en)
        begin
            vf_reg <= ex_vf_wr.data;
        end
    end

    // Operand selection: VF register, forwarded write, memory or reset value.
    assign ex_x = in_item_reg.instruction[11:8];
    assign ex_y = in_item_reg.instruction[7:4];

    always_comb
    begin
        if (ex_x == VF_INDEX)
        begin
            vx = vf_reg;
        end
        else if (hit_x_reg)
        begin
            vx = fwd_data_reg;
        end
        else
        begin
            vx = vld_x_reg ? ram_x : '0;
        end

        if (ex_y == VF_INDEX)
        begin
            vy = vf_reg;
        end
        else if (hit_y_reg)
        begin
            vy = fwd_data_reg;
        end
        else
        begin
            vy = vld_y_reg ? ram_y : '0;
        end
    end

    chip8ie_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (stk_op),
        .level (stk_level),
        .top   (stk_top)
    );

    chip8ie_exec u_exec (
        .item   (in_item_reg),
        .vx     (vx),
        .vy     (vy),
        .vf     (vf_reg),
        .level  (stk_level),
        .top    (stk_top),
        .result (ex_result),
        .rf_wr  (ex_rf_wr),
        .vf_wr  (ex_vf_wr),
        .stk_op (ex_stk_op)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= ex_result;
        end
    end

endmodule

FILE: hdl/chip8ie_checker.sv
// Port-level checker for the instruction execute core, bound to the top level.
// Depends on chip8ie_pkg and chip8_instruction_execute_core_macros.svh.
`include "chip8_instruction_execute_core_macros.svh"

module chip8ie_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 instr_valid,
    input logic                 instr_ready,
    input chip8ie_pkg::instr_t  instr_data,
    input logic                 result_valid,
    input logic                 result_ready,
    input chip8ie_pkg::result_t result_data
);
    import chip8ie_pkg::*;

    // A result that is not taken stays put.
    `CHIP8IE_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data))

    // With the result side empty the core always takes a request.
    `CHIP8IE_ASSERT_IMP(a_ready_when_empty, !result_valid, instr_ready)

    // A new result follows a taken request that passed through the request register.
    `CHIP8IE_ASSERT_IMP(a_result_has_request, $rose(result_valid), $past(instr_valid && instr_ready, 2))

    // A display clear never touches the stack.
    `CHIP8IE_ASSERT_IMP(a_clear_no_stack, result_valid && result_data.clear_screen, result_data.stack_status == STAT_OK)

endmodule

bind chip8_instruction_execute_core chip8ie_checker u_checker (.*);
